// File: src/box_blur_3x3_clipped_unit_assert.svh
// Assertion macros shared by the blur unit's queue and front end modules.
`ifndef BOX_BLUR_3X3_CLIPPED_UNIT_ASSERT_SVH
`define BOX_BLUR_3X3_CLIPPED_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BBC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BBC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/bbc_pkg.sv
// Shared types, constants and the divisor table of the 3x3 clipped box blur.
`default_nettype none

package bbc_pkg;

    // Default sizing
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int RESET_WIDTH    = 640;
    localparam int RESET_HEIGHT   = 480;

    // Pixel and window
    localparam int CH_W  = 8;
    localparam int PIX_W = 24;
    localparam int TAPS  = 9;

    // Configuration port
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 13;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;

    // Mean arithmetic
    localparam int CNT_W       = 4;   // neighbour count 1..9
    localparam int COLSUM_W    = 10;  // three channel values
    localparam int SUM_W       = 12;  // nine channel values
    localparam int NUM_W       = 13;  // 2*sum + n
    localparam int RECIP_W     = 16;
    localparam int RECIP_SHIFT = 16;
    localparam int PROD_W      = NUM_W + RECIP_W;

    // Queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_cfg_reg;

    // One pending result: the window after the shift, which taps count, divisor, end flag
    typedef struct packed {
        logic [TAPS-1:0][PIX_W-1:0] taps;
        logic [TAPS-1:0]            use_mask;
        logic [CNT_W-1:0]           n;
        logic                       last;
    } t_win_entry;

    typedef struct packed {
        logic full;
        logic almost_full;
    } t_q_status;

    // ceil(2^16 / (2n)); exact floor division for numerators below 4600
    function automatic logic [RECIP_W-1:0] f_recip(input logic [CNT_W-1:0] n);
        logic [RECIP_W-1:0] m;
        begin
            case (n)
                4'd1:    m = 16'd32768;
                4'd2:    m = 16'd16384;
                4'd3:    m = 16'd10923;
                4'd4:    m = 16'd8192;
                4'd6:    m = 16'd5462;
                4'd9:    m = 16'd3641;
                default: m = 16'd0;
            endcase
            return m;
        end
    endfunction

endpackage

`default_nettype wire

// File: src/bbc_fifo.sv
// Short queue of pending window entries between the front and the back.
`default_nettype none

`include "box_blur_3x3_clipped_unit_assert.svh"

module bbc_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  bbc_pkg::t_win_entry   i_data,
    input  logic                  i_pop,
    output logic                  o_valid,
    output bbc_pkg::t_win_entry   o_data,
    output bbc_pkg::t_q_status    o_status
);

    bbc_pkg::t_win_entry                  r_mem [bbc_pkg::FIFO_DEPTH];
    logic [bbc_pkg::FIFO_PTR_W-1:0]       r_wr_ptr;
    logic [bbc_pkg::FIFO_PTR_W-1:0]       r_rd_ptr;
    logic [bbc_pkg::FIFO_CNT_W-1:0]       r_count;

    // Status
    assign o_valid              = (r_count != '0);
    assign o_data               = r_mem[r_rd_ptr];
    assign o_status.full        = (r_count == bbc_pkg::FIFO_CNT_W'(bbc_pkg::FIFO_DEPTH));
    assign o_status.almost_full = (r_count >= bbc_pkg::FIFO_CNT_W'(bbc_pkg::FIFO_DEPTH - 1));

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + bbc_pkg::FIFO_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + bbc_pkg::FIFO_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + bbc_pkg::FIFO_CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - bbc_pkg::FIFO_CNT_W'(1);
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `BBC_ASSERT_SAME(a_no_overflow, i_push, r_count < bbc_pkg::FIFO_CNT_W'(bbc_pkg::FIFO_DEPTH), "push into full queue")
    `BBC_ASSERT_SAME(a_no_underflow, i_pop, r_count != '0, "pop from empty queue")
    `BBC_ASSERT_NEXT(a_count_up, i_push && !i_pop, r_count == $past(r_count) + bbc_pkg::FIFO_CNT_W'(1), "fill count lost a push")

endmodule

`default_nettype wire

// File: src/bbc_front.sv
// Front end: configuration registers, input transfer, frame counters, line stores, window taps, result classification.
`default_nettype none

`include "box_blur_3x3_clipped_unit_assert.svh"

module bbc_front #(
    parameter int MAX_WIDTH  = bbc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bbc_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bbc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bbc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_is_pad,
    input  logic [bbc_pkg::CH_W-1:0]          i_red_in,
    input  logic [bbc_pkg::CH_W-1:0]          i_green_in,
    input  logic [bbc_pkg::CH_W-1:0]          i_blue_in,
    input  bbc_pkg::t_q_status                i_q_status,
    output logic                              o_push,
    output bbc_pkg::t_win_entry               o_entry
);

    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WREG_W = COL_W + 1;
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 3);
    localparam int RST_W_VAL =
        (bbc_pkg::RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : bbc_pkg::RESET_WIDTH;
    localparam int RST_H_VAL =
        (bbc_pkg::RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : bbc_pkg::RESET_HEIGHT;

    // Frame geometry and counters
    logic [WREG_W-1:0] r_w;
    logic [ROW_W-1:0]  r_h;
    logic [COL_W-1:0]  r_in_col,  n_in_col;
    logic [ROW_W-1:0]  r_in_row,  n_in_row;
    logic [COL_W-1:0]  r_out_col, n_out_col;
    logic [ROW_W-1:0]  r_out_row, n_out_row;

    // Stage after the transfer: line store read in flight
    logic                                  r_f1_valid;
    logic                                  r_f1_emit;
    logic [COL_W-1:0]                      r_f1_col;
    logic [bbc_pkg::PIX_W-1:0]             r_f1_pix;
    logic [bbc_pkg::TAPS-1:0]              r_f1_use;
    logic [bbc_pkg::CNT_W-1:0]             r_f1_n;
    logic                                  r_f1_last;
    logic                                  r_fwd;
    logic [bbc_pkg::PIX_W-1:0]             r_fwd_old;
    logic [bbc_pkg::PIX_W-1:0]             r_fwd_new;
    logic [bbc_pkg::PIX_W-1:0]             r_old_q;
    logic [bbc_pkg::PIX_W-1:0]             r_new_q;

    // Line stores and window
    logic [bbc_pkg::PIX_W-1:0]                           r_older_mem [MAX_WIDTH];
    logic [bbc_pkg::PIX_W-1:0]                           r_newer_mem [MAX_WIDTH];
    logic [bbc_pkg::TAPS-1:0][bbc_pkg::PIX_W-1:0]        r_taps;
    logic [bbc_pkg::TAPS-1:0][bbc_pkg::PIX_W-1:0]        n_taps;

    logic [bbc_pkg::PIX_W-1:0]       pix;
    logic [bbc_pkg::PIX_W-1:0]       f1_old_eff;
    logic [bbc_pkg::PIX_W-1:0]       f1_new_eff;
    logic                            done;
    logic                            acc;
    logic                            work;
    logic                            emit;
    logic                            c_lo, c_hi, r_lo, r_hi;
    logic                            last_pos;
    logic [2:0]                      col_ok;
    logic [2:0]                      row_ok;
    logic [bbc_pkg::TAPS-1:0]        use_mask;
    logic [1:0]                      cnt_r, cnt_c;
    logic [bbc_pkg::CNT_W-1:0]       n_cnt;
    logic [WREG_W-1:0]               in_col_inc;
    logic [WREG_W-1:0]               out_col_inc;
    logic [WREG_W-1:0]               cfg_w;
    logic [ROW_W-1:0]                cfg_h;
    logic [bbc_pkg::WIDTH_REG_W-1:0] raw_w;
    logic [bbc_pkg::HEIGHT_REG_W-1:0] raw_h;

    // Transfer and classification
    assign pix        = {i_red_in, i_green_in, i_blue_in};
    assign done       = (r_in_row >= r_h);
    assign o_in_stall = i_q_status.full ||
                        (i_q_status.almost_full && r_f1_valid && r_f1_emit);
    assign acc        = i_in_valid && !o_in_stall;
    assign work       = acc && !(i_is_pad && !done);
    assign emit       = (r_in_row >= ROW_W'(2)) ||
                        ((r_in_row == ROW_W'(1)) && (r_in_col != '0));

    // Clipping of the neighbourhood around the next result position
    assign out_col_inc = {1'b0, r_out_col} + WREG_W'(1);
    assign in_col_inc  = {1'b0, r_in_col} + WREG_W'(1);
    assign c_lo     = (r_out_col != '0);
    assign c_hi     = (out_col_inc < r_w);
    assign r_lo     = (r_out_row != '0);
    assign r_hi     = ((r_out_row + ROW_W'(1)) < r_h);
    assign last_pos = !r_hi && !c_hi;
    assign col_ok   = {c_hi, 1'b1, c_lo};
    assign row_ok   = {r_hi, 1'b1, r_lo};
    assign cnt_r    = 2'd1 + {1'b0, r_lo} + {1'b0, r_hi};
    assign cnt_c    = 2'd1 + {1'b0, c_lo} + {1'b0, c_hi};
    assign n_cnt    = {2'b00, cnt_r} * {2'b00, cnt_c};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                use_mask[i*3 + k] = col_ok[i] && row_ok[k];
            end
        end
    end

    // Register values clamped to 1..max
    assign raw_w = i_cfg_data[bbc_pkg::WIDTH_REG_W-1:0];
    assign raw_h = i_cfg_data[bbc_pkg::HEIGHT_REG_W-1:0];

    always_comb begin
        if (raw_w == '0) begin
            cfg_w = WREG_W'(1);
        end else if (32'(raw_w) > MAX_WIDTH) begin
            cfg_w = WREG_W'(MAX_WIDTH);
        end else begin
            cfg_w = WREG_W'(raw_w);
        end
        if (raw_h == '0) begin
            cfg_h = ROW_W'(1);
        end else if (32'(raw_h) > MAX_HEIGHT) begin
            cfg_h = ROW_W'(MAX_HEIGHT);
        end else begin
            cfg_h = ROW_W'(raw_h);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= WREG_W'(RST_W_VAL);
            r_h <= ROW_W'(RST_H_VAL);
        end else if (i_cfg_we) begin
            case (bbc_pkg::t_cfg_reg'(i_cfg_index))
                bbc_pkg::REG_IMAGE_WIDTH:  r_w <= cfg_w;
                bbc_pkg::REG_IMAGE_HEIGHT: r_h <= cfg_h;
                default: ;
            endcase
        end
    end

    // Counter update; a register write or the frame's last result restarts the frame
    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (i_cfg_we) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end else if (work) begin
            if (in_col_inc >= r_w) begin
                n_in_col = '0;
                n_in_row = r_in_row + ROW_W'(1);
            end else begin
                n_in_col = in_col_inc[COL_W-1:0];
            end
            if (emit) begin
                if (last_pos) begin
                    n_in_col  = '0;
                    n_in_row  = '0;
                    n_out_col = '0;
                    n_out_row = '0;
                end else if (out_col_inc >= r_w) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + ROW_W'(1);
                end else begin
                    n_out_col = out_col_inc[COL_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    // Stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
        end else begin
            r_f1_valid <= work;
        end
    end

    // Stage payload; same-column forward when the previous item writes what we read
    always_ff @(posedge i_clk) begin
        if (work) begin
            r_f1_emit <= emit;
            r_f1_col  <= r_in_col;
            r_f1_pix  <= pix;
            r_f1_use  <= use_mask;
            r_f1_n    <= n_cnt;
            r_f1_last <= last_pos;
            r_fwd     <= r_f1_valid && (r_f1_col == r_in_col);
            r_fwd_old <= f1_new_eff;
            r_fwd_new <= r_f1_pix;
        end
    end

    assign f1_old_eff = r_fwd ? r_fwd_old : r_old_q;
    assign f1_new_eff = r_fwd ? r_fwd_new : r_new_q;

    // Line stores: read at the input column, rotate at the stage's column
    always_ff @(posedge i_clk) begin
        r_old_q <= r_older_mem[r_in_col];
        r_new_q <= r_newer_mem[r_in_col];
        if (r_f1_valid) begin
            r_older_mem[r_f1_col] <= f1_new_eff;
            r_newer_mem[r_f1_col] <= r_f1_pix;
        end
    end

    // Window shift: oldest column drops out, new column enters
    always_comb begin
        for (int t = 0; t < 6; t++) begin
            n_taps[t] = r_taps[t + 3];
        end
        n_taps[6] = f1_old_eff;
        n_taps[7] = f1_new_eff;
        n_taps[8] = r_f1_pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taps <= '0;
        end else if (r_f1_valid) begin
            r_taps <= n_taps;
        end
    end

    // Queue push
    assign o_push           = r_f1_valid && r_f1_emit;
    assign o_entry.taps     = n_taps;
    assign o_entry.use_mask = r_f1_use;
    assign o_entry.n        = r_f1_n;
    assign o_entry.last     = r_f1_last;

    `BBC_ASSERT_NEXT(a_pad_ignored, acc && i_is_pad && !done, !r_f1_valid, "early pad entered the pipeline")
    `BBC_ASSERT_SAME(a_push_room, o_push, !i_q_status.full, "push without queue room")
    `BBC_ASSERT_NEXT(a_frame_restart, work && emit && last_pos, (r_in_col == '0) && (r_in_row == '0) && (r_out_col == '0) && (r_out_row == '0), "counters not cleared after frame end")

endmodule

`default_nettype wire

// File: src/bbc_back.sv
// Back end: clipped channel sums, rounded division by the neighbour count, output register.
`default_nettype none

module bbc_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    input  bbc_pkg::t_win_entry          i_entry,
    output logic                         o_pop,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [bbc_pkg::CH_W-1:0]     o_red_out,
    output logic [bbc_pkg::CH_W-1:0]     o_green_out,
    output logic [bbc_pkg::CH_W-1:0]     o_blue_out,
    output logic                         o_frame_last
);

    logic                                         r_b1_valid;
    logic [2:0][bbc_pkg::NUM_W-1:0]               r_b1_x;
    logic [bbc_pkg::RECIP_W-1:0]                  r_b1_m;
    logic                                         r_b1_last;
    logic                                         r_out_valid;
    logic [2:0][bbc_pkg::CH_W-1:0]                r_mean;
    logic                                         r_last;

    logic                                         out_adv;
    logic                                         b1_adv;
    logic [2:0][2:0][bbc_pkg::COLSUM_W-1:0]       col_sum;
    logic [2:0][bbc_pkg::SUM_W-1:0]               sum;
    logic [2:0][bbc_pkg::NUM_W-1:0]               num;
    logic [2:0][bbc_pkg::PROD_W-1:0]              prod;

    // Pipeline flow
    assign out_adv = !r_out_valid || !i_out_stall;
    assign b1_adv  = !r_b1_valid || out_adv;
    assign o_pop   = i_q_valid && b1_adv;

    // Masked sums per column then across columns; numerator 2*sum + n
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            for (int i = 0; i < 3; i++) begin
                col_sum[ch][i] = '0;
                for (int k = 0; k < 3; k++) begin
                    if (i_entry.use_mask[i*3 + k]) begin
                        col_sum[ch][i] = col_sum[ch][i] +
                            {2'b00, i_entry.taps[i*3 + k][(2 - ch)*bbc_pkg::CH_W +: bbc_pkg::CH_W]};
                    end
                end
            end
            sum[ch] = {2'b00, col_sum[ch][0]} + {2'b00, col_sum[ch][1]} +
                      {2'b00, col_sum[ch][2]};
            num[ch] = {sum[ch], 1'b0} +
                      {{(bbc_pkg::NUM_W - bbc_pkg::CNT_W){1'b0}}, i_entry.n};
        end
    end

    // Reciprocal multiply gives floor(num / 2n)
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            prod[ch] = {{bbc_pkg::RECIP_W{1'b0}}, r_b1_x[ch]} *
                       {{bbc_pkg::NUM_W{1'b0}}, r_b1_m};
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (b1_adv) begin
                r_b1_valid <= i_q_valid;
            end
            if (out_adv) begin
                r_out_valid <= r_b1_valid;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b1_x    <= num;
            r_b1_m    <= bbc_pkg::f_recip(i_entry.n);
            r_b1_last <= i_entry.last;
        end
        if (out_adv && r_b1_valid) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_mean[ch] <= prod[ch][bbc_pkg::RECIP_SHIFT +: bbc_pkg::CH_W];
            end
            r_last <= r_b1_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_red_out    = r_mean[0];
    assign o_green_out  = r_mean[1];
    assign o_blue_out   = r_mean[2];
    assign o_frame_last = r_last;

endmodule

`default_nettype wire

// File: src/box_blur_3x3_clipped_unit.sv
// Top level of the 3x3 clipped box blur: front end, pending queue, back end.
// RGB pixels enter in raster order, one transfer per clock when the output is
// not stalled. Each result is the rounded (half up) mean of every channel over
// the pixel's 3x3 neighbourhood, clipped at the frame borders. A result leaves
// one row plus one pixel after its pixel enters, so after the last pixel of a
// frame send width+1 pad items to drain it; frame_last marks the frame's final
// result and the next pixel starts a new frame. Pads sent before the frame's
// pixels are all in are dropped. Sustained rate is one item per clock while the
// output is not stalled: the line stores are two MAX_WIDTH x 24 RAMs with one
// read and one write per clock and a same-column forward. Input stalls when the
// 4-entry result queue is full, or holds three entries with one more push
// already in flight. Results pass the front stage, queue, back stage and output
// registers. Writing image_width or image_height restarts the frame; do it only
// while no results are pending. Line stores need no clearing pass after reset.
`default_nettype none

module box_blur_3x3_clipped_unit #(
    parameter int MAX_WIDTH  = bbc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bbc_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bbc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bbc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_is_pad,
    input  logic [bbc_pkg::CH_W-1:0]          i_red_in,
    input  logic [bbc_pkg::CH_W-1:0]          i_green_in,
    input  logic [bbc_pkg::CH_W-1:0]          i_blue_in,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [bbc_pkg::CH_W-1:0]          o_red_out,
    output logic [bbc_pkg::CH_W-1:0]          o_green_out,
    output logic [bbc_pkg::CH_W-1:0]          o_blue_out,
    output logic                              o_frame_last
);

    logic                  push;
    logic                  pop;
    logic                  q_valid;
    bbc_pkg::t_win_entry   push_entry;
    bbc_pkg::t_win_entry   q_entry;
    bbc_pkg::t_q_status    q_status;

    // Input transfer, line stores and window
    bbc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_is_pad    (i_is_pad),
        .i_red_in    (i_red_in),
        .i_green_in  (i_green_in),
        .i_blue_in   (i_blue_in),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    // Pending results
    bbc_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (push_entry),
        .i_pop    (pop),
        .o_valid  (q_valid),
        .o_data   (q_entry),
        .o_status (q_status)
    );

    // Means and output register
    bbc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_entry      (q_entry),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_red_out    (o_red_out),
        .o_green_out  (o_green_out),
        .o_blue_out   (o_blue_out),
        .o_frame_last (o_frame_last)
    );

endmodule

`default_nettype wire
